// ----- src/rfed_pkg.sv -----
package rfed_pkg;

    localparam int TIME_W     = 32;
    localparam int NOISE_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ALT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE      = 3'd5;

    localparam int RST_LAUNCH_THR = 160;
    localparam int RST_GOAL_ALT   = 8000;
    localparam int RST_FLOOR      = 6400;
    localparam int RST_TIMEOUT    = 11000;
    localparam int RST_OFFSET     = 0;
    localparam int RST_NOISE      = 16;

    localparam logic [1:0] CNT_HIT = 2'd3;

    typedef struct packed {
        logic load;
        logic push;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

// ----- src/rfed_in_if.sv -----
interface rfed_in_if #(
    parameter int ALT_WIDTH = 21
);
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [31:0]                 now_ms;
    logic signed [ALT_WIDTH-1:0] raw_altitude;

    modport source (output valid, output func, output now_ms, output raw_altitude,
                    input ready);
    modport sink (input valid, input func, input now_ms, input raw_altitude,
                  output ready);
endinterface

// ----- src/rfed_out_if.sv -----
interface rfed_out_if #(
    parameter int ALT_WIDTH = 21
);
    logic                        valid;
    logic                        ready;
    logic                        launched;
    logic                        goal_reached;
    logic                        deploy;
    logic signed [ALT_WIDTH-1:0] apogee;
    logic [31:0]                 flight_time_ms;
    logic                        descending;

    modport source (output valid, output launched, output goal_reached, output deploy,
                    output apogee, output flight_time_ms, output descending,
                    input ready);
    modport sink (input valid, input launched, input goal_reached, input deploy,
                  input apogee, input flight_time_ms, input descending,
                  output ready);
    modport mon (input valid, input ready, input launched, input goal_reached,
                 input deploy, input apogee, input flight_time_ms, input descending);
endinterface

// ----- src/rfed_ctrl.sv -----
module rfed_ctrl
    import rfed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PUSH   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- src/rfed_dp.sv -----
module rfed_dp
    import rfed_pkg::*;
#(
    parameter int WINDOW_DEPTH = 6,
    parameter int ALT_WIDTH    = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                        i_func,
    input  logic [TIME_W-1:0]           i_now_ms,
    input  logic signed [ALT_WIDTH-1:0] i_raw_altitude,
    output logic                        o_launched,
    output logic                        o_goal_reached,
    output logic                        o_deploy,
    output logic signed [ALT_WIDTH-1:0] o_apogee,
    output logic [TIME_W-1:0]           o_flight_time_ms,
    output logic                        o_descending
);

    localparam int D  = WINDOW_DEPTH;
    localparam int W  = ALT_WIDTH;
    localparam int IW = $clog2(D);
    localparam int FW = $clog2(D + 1);
    localparam int SW = $clog2(2 * D) + 1;
    localparam int DW = ((W > NOISE_W) ? W : NOISE_W) + 2;

    logic signed [W-1:0]       r_thr, r_goal, r_floor, r_offset;
    logic [TIME_W-1:0]         r_timeout;
    logic [NOISE_W-1:0]        r_noise;

    logic                      r_func;
    logic [TIME_W-1:0]         r_now;
    logic signed [W-1:0]       r_raw;

    logic signed [W-1:0]       r_win [D];
    logic [FW-1:0]             r_fill;

    logic                      r_launched, r_goal_flag, r_deploy;
    logic [TIME_W-1:0]         r_launch_time;
    logic signed [W-1:0]       r_highest;

    logic [IW-1:0]             r_idx;
    logic [1:0]                r_cnt_thr, r_cnt_goal, r_cnt_floor;
    logic                      r_mono;
    logic signed [W-1:0]       r_prev_ent;

    logic                      r_o_launched, r_o_goal, r_o_deploy, r_o_desc;
    logic signed [W-1:0]       r_o_apogee;
    logic [TIME_W-1:0]         r_o_ftime;

    logic signed [W-1:0]       alt_clamp;
    logic signed [W:0]         alt_diff;
    logic signed [W-1:0]       alt_sat;

    logic signed [W-1:0]       cur;
    logic [SW-1:0]             pos_sum;
    logic                      ent_valid, examined, prev_valid;

    logic signed [DW-1:0]      d_diff, nb_pos;
    logic                      noise_hit, falling;
    logic [TIME_W-1:0]         ftime;
    logic                      launch_now, timeout_hit;

    always_comb begin
        alt_clamp = r_raw[W-1] ? '0 : r_raw;
        alt_diff  = (W + 1)'(alt_clamp) - (W + 1)'(r_offset);
        if (alt_diff[W] != alt_diff[W-1]) begin
            alt_sat = alt_diff[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end else begin
            alt_sat = alt_diff[W-1:0];
        end
    end

    always_comb begin
        cur        = r_win[r_idx];
        pos_sum    = SW'(r_idx) + SW'(r_fill);
        ent_valid  = (pos_sum >= SW'(D));
        examined   = ent_valid && (SW'(r_idx) <= SW'(D - 4));
        prev_valid = (pos_sum >= SW'(D + 1));
    end

    always_comb begin
        d_diff      = DW'(r_win[D-1]) - DW'(r_win[D-2]);
        nb_pos      = signed'(DW'(r_noise));
        noise_hit   = (d_diff > -nb_pos) && (d_diff < nb_pos);
        falling     = (r_fill >= FW'(2)) && !noise_hit && r_mono;
        ftime       = r_now - r_launch_time;
        timeout_hit = (ftime > r_timeout);
        launch_now  = !r_launched && (r_cnt_thr == CNT_HIT);
    end

    assign o_sts.scan_last = (r_idx == IW'(D - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= W'(RST_LAUNCH_THR);
            r_goal    <= W'(RST_GOAL_ALT);
            r_floor   <= W'(RST_FLOOR);
            r_timeout <= TIME_W'(RST_TIMEOUT);
            r_offset  <= W'(RST_OFFSET);
            r_noise   <= NOISE_W'(RST_NOISE);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LAUNCH_THR: r_thr     <= signed'(i_cfg_wdata[W-1:0]);
                CFG_GOAL_ALT:   r_goal    <= signed'(i_cfg_wdata[W-1:0]);
                CFG_FLOOR:      r_floor   <= signed'(i_cfg_wdata[W-1:0]);
                CFG_TIMEOUT:    r_timeout <= i_cfg_wdata[TIME_W-1:0];
                CFG_OFFSET:     r_offset  <= signed'(i_cfg_wdata[W-1:0]);
                CFG_NOISE:      r_noise   <= i_cfg_wdata[NOISE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_now  <= i_now_ms;
            r_raw  <= i_raw_altitude;
        end
        if (i_cmd.push && !r_func) begin
            for (int j = 0; j < D - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[D-1] <= alt_sat;
        end
        if (i_cmd.push) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx      <= r_idx + IW'(1);
            r_prev_ent <= cur;
        end
        if (i_cmd.commit) begin
            r_o_launched <= r_launched || launch_now;
            r_o_apogee   <= r_highest;
            if (!r_launched) begin
                r_o_goal   <= r_goal_flag;
                r_o_deploy <= r_deploy;
                r_o_ftime  <= '0;
                r_o_desc   <= 1'b0;
            end else begin
                r_o_goal   <= r_goal_flag || (r_cnt_goal == CNT_HIT);
                r_o_deploy <= r_deploy || timeout_hit || (falling && r_cnt_floor == CNT_HIT);
                r_o_ftime  <= ftime;
                r_o_desc   <= !r_deploy && falling;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_launched    <= 1'b0;
            r_goal_flag   <= 1'b0;
            r_deploy      <= 1'b0;
            r_launch_time <= '0;
            r_highest     <= '0;
            r_cnt_thr     <= '0;
            r_cnt_goal    <= '0;
            r_cnt_floor   <= '0;
            r_mono        <= 1'b1;
        end else begin
            if (i_cmd.push) begin
                if (!r_func && r_fill != FW'(D)) begin
                    r_fill <= r_fill + FW'(1);
                end
                r_cnt_thr   <= '0;
                r_cnt_goal  <= '0;
                r_cnt_floor <= '0;
                r_mono      <= 1'b1;
            end else if (i_cmd.step) begin
                if (examined) begin
                    if (cur > r_thr && r_cnt_thr != CNT_HIT) begin
                        r_cnt_thr <= r_cnt_thr + 2'd1;
                    end
                    if (cur > r_goal && r_cnt_goal != CNT_HIT) begin
                        r_cnt_goal <= r_cnt_goal + 2'd1;
                    end
                    if (cur < r_floor && r_cnt_floor != CNT_HIT) begin
                        r_cnt_floor <= r_cnt_floor + 2'd1;
                    end
                    if (r_launched && cur > r_highest) begin
                        r_highest <= cur;
                    end
                end
                if (prev_valid && r_prev_ent < cur) begin
                    r_mono <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                if (launch_now) begin
                    r_launched    <= 1'b1;
                    r_launch_time <= r_now;
                end
                if (r_launched) begin
                    if (r_cnt_goal == CNT_HIT) begin
                        r_goal_flag <= 1'b1;
                    end
                    if (timeout_hit || (falling && r_cnt_floor == CNT_HIT)) begin
                        r_deploy <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_launched       = r_o_launched;
    assign o_goal_reached   = r_o_goal;
    assign o_deploy         = r_o_deploy;
    assign o_apogee         = r_o_apogee;
    assign o_flight_time_ms = r_o_ftime;
    assign o_descending     = r_o_desc;

endmodule

// ----- src/rocket_flight_event_detector.sv -----
// Flight event detector for a sounding rocket.
// Input channel i_in carries one item per transfer: func 0 is an altitude
// sample (clamped at zero, ground offset removed, pushed into the window),
// func 1 is a time tick that only re-evaluates. Output channel o_out returns
// exactly one result per input item, in order: launched, goal_reached,
// sticky deploy, apogee, flight time and the descending check of that step.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
// while no item is in flight; registers take effect on the next item.
// From the input transfer to o_out.valid the sample is pushed, the scan unit
// walks the window one entry per cycle, and the decide step registers the
// result; a stalled receiver can hold the result in the decide step.
// The block takes no new item before it is through with the last one: the
// single scan unit visits the window entries one per cycle, and the next
// transfer is taken only in the idle state.
// Reset (synchronous, active low) empties the window, clears all flags,
// apogee and launch time, and restores the register defaults.
// When the receiver stalls, the finished result holds in the output register
// and the next item is still accepted; its result waits in the decide step
// until the output register is taken.
module rocket_flight_event_detector
    import rfed_pkg::*;
#(
    parameter int WINDOW_DEPTH = 6,
    parameter int ALT_WIDTH    = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rfed_in_if.sink               i_in,
    rfed_out_if.source            o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rfed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rfed_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ALT_WIDTH    (ALT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (i_in.func),
        .i_now_ms         (i_in.now_ms),
        .i_raw_altitude   (i_in.raw_altitude),
        .o_launched       (o_out.launched),
        .o_goal_reached   (o_out.goal_reached),
        .o_deploy         (o_out.deploy),
        .o_apogee         (o_out.apogee),
        .o_flight_time_ms (o_out.flight_time_ms),
        .o_descending     (o_out.descending)
    );

endmodule

// ----- src/rfed_checker.sv -----
module rfed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    rfed_out_if.source o_out
);

    logic r_seen_launch, r_seen_deploy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_launch <= 1'b0;
            r_seen_deploy <= 1'b0;
        end else if (o_out.valid && o_out.ready) begin
            if (o_out.launched) begin
                r_seen_launch <= 1'b1;
            end
            if (o_out.deploy) begin
                r_seen_deploy <= 1'b1;
            end
        end
    end

    a_launch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_seen_launch |-> o_out.launched)
        else $error("launched dropped after a transfer showed it");

    a_deploy_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_seen_deploy |-> o_out.deploy)
        else $error("deploy dropped after a transfer showed it");

    a_prelaunch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.launched |->
            o_out.flight_time_ms == 32'd0 && !o_out.descending &&
            !o_out.goal_reached && !o_out.deploy)
        else $error("flight result shown before launch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=>
            o_out.valid && $stable(o_out.apogee) && $stable(o_out.flight_time_ms) &&
            $stable(o_out.deploy) && $stable(o_out.descending))
        else $error("stalled result changed");

endmodule

bind rocket_flight_event_detector rfed_checker u_rfed_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);

// ----- tb/tb_rocket_flight_event_detector.sv -----
`timescale 1ns / 1ps

localparam int ALT_W     = 21;
localparam int WIN_DEPTH = 6;
localparam longint ALT_MAX = (longint'(1) <<< (ALT_W - 1)) - 1;
localparam longint ALT_MIN = -(longint'(1) <<< (ALT_W - 1));

typedef logic signed [ALT_W-1:0] t_alt;

typedef struct packed {
    logic        launched;
    logic        goal_reached;
    logic        deploy;
    t_alt        apogee;
    logic [31:0] flight_time_ms;
    logic        descending;
} t_flight_status;

class flight_scoreboard;
    longint         launch_thr;
    longint         goal_alt;
    longint         floor_alt;
    longint         ground_off;
    longint         noise_band;
    logic [31:0]    timeout_ms;
    longint         window[WIN_DEPTH];
    int             fill;
    bit             launched;
    bit             goal_hit;
    bit             deployed;
    logic [31:0]    t_launch;
    longint         apex;
    t_flight_status status_due_q[$];
    int             errors;

    function new();
        launch_thr = rfed_pkg::RST_LAUNCH_THR;
        goal_alt   = rfed_pkg::RST_GOAL_ALT;
        floor_alt  = rfed_pkg::RST_FLOOR;
        timeout_ms = rfed_pkg::RST_TIMEOUT;
        ground_off = rfed_pkg::RST_OFFSET;
        noise_band = rfed_pkg::RST_NOISE;
        foreach (window[i]) window[i] = 0;
        fill     = 0;
        launched = 0;
        goal_hit = 0;
        deployed = 0;
        t_launch = '0;
        apex     = 0;
        errors   = 0;
    endfunction

    function void write_reg(logic [rfed_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        t_alt a;
        a = t_alt'(data);
        case (idx)
            rfed_pkg::CFG_LAUNCH_THR: launch_thr = a;
            rfed_pkg::CFG_GOAL_ALT:   goal_alt = a;
            rfed_pkg::CFG_FLOOR:      floor_alt = a;
            rfed_pkg::CFG_TIMEOUT:    timeout_ms = data;
            rfed_pkg::CFG_OFFSET:     ground_off = a;
            rfed_pkg::CFG_NOISE:      noise_band = longint'(data[rfed_pkg::NOISE_W-1:0]);
            default: ;
        endcase
    endfunction

    // Count the examined entries, i.e. all but the newest three, that lie above (or below) lim.
    function int count_examined(longint lim, bit above);
        int n;
        n = 0;
        for (int i = 0; i + 3 < fill; i++) begin
            if (above ? window[i] > lim : window[i] < lim) n++;
        end
        return n;
    endfunction

    function bit window_falling();
        longint d;
        if (fill < 2) return 1'b0;
        d = window[fill-1] - window[fill-2];
        if (d > -noise_band && d < noise_band) return 1'b0;
        for (int i = 0; i + 1 < fill; i++) begin
            if (window[i] < window[i+1]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function int pending();
        return status_due_q.size();
    endfunction

    function void take_item(logic f, logic [31:0] now, t_alt raw);
        longint         alt;
        logic [31:0]    ft;
        bit             dsc;
        t_flight_status st;
        ft  = '0;
        dsc = 1'b0;
        if (!f) begin
            alt = raw;
            if (alt < 0) alt = 0;
            alt -= ground_off;
            if (alt > ALT_MAX) alt = ALT_MAX;
            if (alt < ALT_MIN) alt = ALT_MIN;
            if (fill < WIN_DEPTH) begin
                window[fill] = alt;
                fill++;
            end else begin
                for (int i = 0; i + 1 < WIN_DEPTH; i++) window[i] = window[i+1];
                window[WIN_DEPTH-1] = alt;
            end
        end
        if (!launched) begin
            if (count_examined(launch_thr, 1'b1) >= rfed_pkg::CNT_HIT) begin
                launched = 1'b1;
                t_launch = now;
            end
        end else begin
            ft = now - t_launch;
            for (int i = 0; i + 3 < fill; i++) begin
                if (window[i] > apex) apex = window[i];
            end
            if (count_examined(goal_alt, 1'b1) >= rfed_pkg::CNT_HIT) goal_hit = 1'b1;
            if (!deployed) begin
                if (ft > timeout_ms) deployed = 1'b1;
                dsc = window_falling();
                if (dsc && count_examined(floor_alt, 1'b0) >= rfed_pkg::CNT_HIT) begin
                    deployed = 1'b1;
                end
            end
        end
        if (launched) ft = now - t_launch;
        st.launched       = launched;
        st.goal_reached   = goal_hit;
        st.deploy         = deployed;
        st.apogee         = t_alt'(apex);
        st.flight_time_ms = ft;
        st.descending     = dsc;
        status_due_q.push_back(st);
    endfunction

    function void mismatch(string field, logic signed [63:0] want, logic signed [63:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_status(t_flight_status got);
        t_flight_status want;
        if (status_due_q.size() == 0) begin
            errors++;
            $display("%0t ns: result with no item outstanding, actual %h", $time, got);
            return;
        end
        want = status_due_q.pop_front();
        if (got.launched !== want.launched)
            mismatch("launched", want.launched, got.launched);
        if (got.goal_reached !== want.goal_reached)
            mismatch("goal_reached", want.goal_reached, got.goal_reached);
        if (got.deploy !== want.deploy)
            mismatch("deploy", want.deploy, got.deploy);
        if (got.apogee !== want.apogee)
            mismatch("apogee", $signed(want.apogee), $signed(got.apogee));
        if (got.flight_time_ms !== want.flight_time_ms)
            mismatch("flight_time_ms", want.flight_time_ms, got.flight_time_ms);
        if (got.descending !== want.descending)
            mismatch("descending", want.descending, got.descending);
    endfunction
endclass

module tb_rocket_flight_event_detector;
    import rfed_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_NOISE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum int {RX_FREE, RX_CHOPPY, RX_SLOW} t_rx_mode;
    typedef enum int {FLY_CLIMB, FLY_DESCEND, FLY_HOVER, FLY_JITTER, FLY_WILD} t_fly_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rfed_in_if  #(.ALT_WIDTH(ALT_W)) in_ch ();
    rfed_out_if #(.ALT_WIDTH(ALT_W)) out_ch ();

    rocket_flight_event_detector #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .ALT_WIDTH    (ALT_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    flight_scoreboard sb;

    t_rx_mode    rx_mode     = RX_FREE;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          gap_max     = 0;
    t_fly_mode   fly_mode    = FLY_HOVER;
    int          seg_left    = 0;
    longint      slope       = 0;
    longint      alt_now     = 0;
    logic [31:0] clock_ms    = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall pattern.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    out_ch.ready <= 1'b1;
                    stall_left = 15;
                end
                RX_CHOPPY: begin
                    out_ch.ready <= 1'($urandom_range(0, 1));
                    stall_left = $urandom_range(0, 2);
                end
                default: begin
                    if (out_ch.ready) begin
                        out_ch.ready <= 1'b0;
                        stall_left = $urandom_range(4, 19);
                    end else begin
                        out_ch.ready <= 1'b1;
                        stall_left = $urandom_range(0, 3);
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_status({out_ch.launched, out_ch.goal_reached, out_ch.deploy,
                                 out_ch.apogee, out_ch.flight_time_ms, out_ch.descending});
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(logic f, logic [31:0] now, t_alt raw);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.func         <= f;
        in_ch.now_ms       <= now;
        in_ch.raw_altitude <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_item(f, now, raw);
        @(negedge i_clk);
    endtask

    // Drain every outstanding result before touching the registers.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        sb.write_reg(idx, value[31:0]);
        @(negedge i_clk);
    endtask

    task automatic begin_phase();
        i_cfg_wr_en <= 1'b0;
        rx_mode = t_rx_mode'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 4;
            default: gap_max = 15;
        endcase
        burst_left = 0;
    endtask

    task automatic send_noise(int n);
        for (int k = 0; k < n; k++) begin
            send_item($urandom_range(0, 3) == 0, $urandom, t_alt'($urandom));
        end
    endtask

    // Flight-like altitude profile: climbs, descents, hovering, jitter and wild stretches.
    task automatic fly(int n);
        for (int k = 0; k < n; k++) begin
            if (seg_left == 0) begin
                fly_mode = t_fly_mode'($urandom_range(0, 4));
                seg_left = $urandom_range(3, 24);
                slope    = longint'($urandom_range(1, 800));
            end
            seg_left--;
            case (fly_mode)
                FLY_CLIMB:   alt_now += slope;
                FLY_DESCEND: alt_now -= slope;
                FLY_HOVER:   ;
                FLY_JITTER:  alt_now += longint'($urandom_range(0, 64)) - 32;
                default:     alt_now = longint'(t_alt'($urandom));
            endcase
            if (alt_now > ALT_MAX) alt_now = ALT_MAX;
            if (alt_now < ALT_MIN) alt_now = ALT_MIN;
            clock_ms += 32'($urandom_range(50, 300));
            send_item($urandom_range(0, 6) == 0, clock_ms, t_alt'(alt_now));
        end
    endtask

    initial begin
        longint thr_ground;
        longint off;
        sb = new();
        in_ch.valid        <= 1'b0;
        in_ch.func         <= 1'b0;
        in_ch.now_ms       <= '0;
        in_ch.raw_altitude <= '0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_index        <= CFG_LAUNCH_THR;
        i_cfg_wdata        <= '0;
        i_rst_n            <= 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: ticks on an empty window, clamping, threshold edges.
        begin_phase();
        send_item(1'b1, 32'd0, t_alt'(0));
        send_item(1'b0, 32'd200, t_alt'(ALT_MIN));
        send_item(1'b1, 32'hFFFF_FFFF, t_alt'(0));
        send_item(1'b0, 32'd400, t_alt'(-1));
        send_item(1'b0, 32'd600, t_alt'(ALT_MAX));
        send_item(1'b0, 32'd800, t_alt'(0));
        send_item(1'b0, 32'd1000, t_alt'(RST_LAUNCH_THR));
        send_item(1'b0, 32'd1200, t_alt'(RST_LAUNCH_THR + 1));
        send_item(1'b0, 32'd1400, t_alt'(ALT_MAX));
        send_item(1'b1, 32'd1600, t_alt'(ALT_MAX));
        send_item(1'b0, 32'd1800, t_alt'(170));

        // Offset saturation at both ends; unmapped indexes must be ignored.
        quiesce();
        cfg_write(CFG_LAUNCH_THR, ALT_MAX);
        cfg_write(CFG_OFFSET, ALT_MIN);
        cfg_write(CFG_SPARE_LO, longint'($urandom));
        cfg_write(CFG_SPARE_HI, longint'($urandom));
        begin_phase();
        send_item(1'b0, 32'd2000, t_alt'(0));
        send_item(1'b0, 32'd2200, t_alt'(ALT_MAX));
        quiesce();
        cfg_write(CFG_OFFSET, ALT_MAX);
        begin_phase();
        send_item(1'b0, 32'd2400, t_alt'(-5));
        send_item(1'b0, 32'd2600, t_alt'(ALT_MAX));
        send_item(1'b0, 32'd2800, t_alt'(0));

        // Pre-launch noise with an unreachable threshold.
        for (int p = 0; p < 3; p++) begin
            off = (p == 0) ? ALT_MIN : (p == 1) ? ALT_MAX : longint'(t_alt'($urandom));
            quiesce();
            cfg_write(CFG_OFFSET, off);
            begin_phase();
            send_noise(40);
        end

        // Ground noise with occasional spikes above the threshold.
        quiesce();
        thr_ground = longint'($urandom_range(100, 50000));
        cfg_write(CFG_LAUNCH_THR, thr_ground);
        cfg_write(CFG_OFFSET, longint'($urandom_range(0, 2000)));
        cfg_write(CFG_TIMEOUT, 32'hFFFF_FFFF);
        cfg_write(CFG_FLOOR, ALT_MIN);
        begin_phase();
        for (int k = 0; k < 100; k++) begin
            clock_ms = $urandom;
            if ($urandom_range(0, 7) == 0) begin
                send_item(1'b0, clock_ms,
                          t_alt'(thr_ground + longint'($urandom_range(1, 500))));
            end else begin
                send_item($urandom_range(0, 5) == 0, clock_ms,
                          t_alt'(longint'($urandom_range(0, 2100)) - 2000));
            end
        end

        // Launch close to the millisecond wrap.
        quiesce();
        cfg_write(CFG_LAUNCH_THR, RST_LAUNCH_THR);
        cfg_write(CFG_OFFSET, RST_OFFSET);
        cfg_write(CFG_GOAL_ALT, ALT_MAX);
        cfg_write(CFG_NOISE, RST_NOISE);
        begin_phase();
        clock_ms = 32'hFFFF_F800;
        alt_now  = 400;
        for (int k = 0; k < 40 && !sb.launched; k++) begin
            alt_now  += 250;
            clock_ms += 32'd200;
            send_item(1'b0, clock_ms, t_alt'(alt_now));
        end

        // Flight with deploy held off: falling check and goal across settings.
        for (int p = 0; p < 4; p++) begin
            quiesce();
            case (p)
                0: cfg_write(CFG_NOISE, 0);
                1: begin
                    cfg_write(CFG_NOISE, 32'hFFFF_FFFF);
                    cfg_write(CFG_GOAL_ALT, longint'($urandom_range(2000, 40000)));
                end
                2: begin
                    cfg_write(CFG_NOISE, RST_NOISE);
                    cfg_write(CFG_LAUNCH_THR, ALT_MIN);
                end
                default: begin
                    cfg_write(CFG_NOISE, longint'($urandom_range(0, 3000)));
                    cfg_write(CFG_GOAL_ALT, ALT_MIN);
                end
            endcase
            begin_phase();
            fly(130);
        end

        // Let recovery deploy, by timeout or by falling below the floor.
        quiesce();
        cfg_write(CFG_FLOOR, $urandom_range(0, 1) ? longint'(RST_FLOOR) : ALT_MAX);
        cfg_write(CFG_TIMEOUT, $urandom_range(0, 1) ?
                  longint'(clock_ms - sb.t_launch) + longint'($urandom_range(500, 20000)) :
                  longint'(32'hFFFF_FFFF));
        cfg_write(CFG_NOISE, longint'($urandom_range(0, 200)));
        begin_phase();
        for (int k = 0; k < 250 && !sb.deployed; k++) fly(1);

        // After deploy: sticky flags, apogee and goal keep going.
        quiesce();
        cfg_write(CFG_TIMEOUT, 0);
        cfg_write(CFG_FLOOR, ALT_MAX);
        cfg_write(CFG_GOAL_ALT, longint'($urandom_range(0, 100000)));
        cfg_write(CFG_NOISE, longint'($urandom_range(0, 5000)));
        begin_phase();
        fly(240);

        quiesce();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- rocket_flight_event_detector.f -----
src/rfed_pkg.sv
src/rfed_in_if.sv
src/rfed_out_if.sv
src/rfed_ctrl.sv
src/rfed_dp.sv
src/rocket_flight_event_detector.sv
src/rfed_checker.sv
tb/tb_rocket_flight_event_detector.sv
